@@ src/cfdl_pkg.sv @@
// Shared types and constants of the cubic fractional delay line.
// Depends on nothing; the top level and cfdl_interp import it.
`default_nettype none

package cfdl_pkg;

    localparam int DEPTH    = 131072;
    localparam int GUARD    = 4;
    localparam int SAMPLE_W = 24;
    localparam int DLY_W    = 33;
    localparam int FRAC_W   = 16;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int RP_W     = ADDR_W + FRAC_W;
    localparam int CMP_W    = (RP_W + 1 > DLY_W) ? RP_W + 1 : DLY_W;
    localparam int SUM_W    = CMP_W + 1;
    localparam int ACC_W    = 30;
    localparam int PROD_W   = ACC_W + FRAC_W + 1;

    localparam logic [CMP_W-1:0]  DLY_MIN   = CMP_W'(1) << FRAC_W;
    localparam logic [CMP_W-1:0]  DLY_MAX   = CMP_W'(DEPTH - GUARD) << FRAC_W;
    localparam logic [SUM_W-1:0]  SPAN      = SUM_W'(DEPTH) << FRAC_W;
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (FRAC_W - 1);
    localparam logic signed [ACC_W-1:0]  ACC_ONE   = ACC_W'(1);
    localparam logic signed [ACC_W-1:0]  SAT_MAX   = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0]  SAT_MIN   = -(ACC_W'(1) << (SAMPLE_W - 1));

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t [3:0] tap_vec_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic              start;
        logic [FRAC_W-1:0] frac;
    } cfdl_req_t;

    typedef struct packed {
        logic    done;
        sample_t result;
    } cfdl_stat_t;

endpackage

`default_nettype wire

@@ src/cubic_fractional_delay_line_top.sv @@
// Top level of the cubic fractional delay line: sequencer, ring pointer and output register.
// Depends on cfdl_pkg, cfdl_ram and cfdl_interp.
//
// Each accepted word carries a new sample and a Q17.16 delay, clamped to one sample
// at least and DEPTH-GUARD samples at most. The block reads four neighbouring samples
// from a single-port-read ring buffer, one per cycle, writes the new sample, and then
// evaluates the Catmull-Rom cubic with one shared multiplier in three Horner steps.
// A word is finished, through the four buffer reads and the six multiply and round
// steps, before the next one can be accepted; a result that is not taken holds the
// block in its final state. The buffer needs no clearing pass:
// entries not yet written since reset read as zero, judged from the write pointer.
`default_nettype none

module cubic_fractional_delay_line_top
    import cfdl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [SAMPLE_W-1:0] write_sample,
    input  wire logic [DLY_W-1:0]    delay_amount,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [SAMPLE_W-1:0]      read_sample
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_POS   = 7'b0000010,
        S_PREP  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_WRITE = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] sample_reg;
    logic [DLY_W-1:0]    dly_reg;
    logic [ADDR_W-1:0]   i0_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [1:0]          cnt_reg;
    logic [ADDR_W-1:0]   wp_reg;
    logic                wrapped_reg;
    logic                rd_pend_reg;
    logic                rd_ok_reg;
    logic [1:0]          rd_slot_reg;
    tap_vec_t            tap_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_data_reg;

    logic [CMP_W-1:0]    dly_ext;
    logic [CMP_W-1:0]    dly_clamped;
    logic [SUM_W-1:0]    rp_sum;
    logic [SUM_W-1:0]    rp_wrap;
    logic [ADDR_W-1:0]   addr_inc;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic                ram_we;
    logic                ram_re;
    logic                out_free;
    cfdl_req_t           ireq;
    cfdl_stat_t          ist;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign read_sample = out_data_reg;
    assign out_free    = !out_valid_reg || out_ready;

    assign dly_ext = CMP_W'(dly_reg);

    always_comb
    begin
        if (dly_ext < DLY_MIN)
        begin
            dly_clamped = DLY_MIN;
        end
        else if (dly_ext > DLY_MAX)
        begin
            dly_clamped = DLY_MAX;
        end
        else
        begin
            dly_clamped = dly_ext;
        end
    end

    assign rp_sum   = SUM_W'({wp_reg, {FRAC_W{1'b0}}}) + SPAN - SUM_W'(dly_clamped);
    assign rp_wrap  = (rp_sum >= SPAN) ? rp_sum - SPAN : rp_sum;
    assign addr_inc = (addr_reg == ADDR_LAST) ? '0 : addr_reg + ADDR_W'(1);

    assign ram_re = (state_reg == S_READ);
    assign ram_we = (state_reg == S_WRITE);

    assign ireq.start = (state_reg == S_WRITE);
    assign ireq.frac  = frac_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_POS;
                end
            end
            S_POS:   state_next = S_PREP;
            S_PREP:  state_next = S_READ;
            S_READ:  state_next = (cnt_reg == 2'd3) ? S_WRITE : S_READ;
            S_WRITE: state_next = S_WAIT;
            S_WAIT:
            begin
                if (ist.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 2'd0;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= ram_re;
            if (state_reg == S_PREP)
            begin
                cnt_reg <= 2'd0;
            end
            else if (state_reg == S_READ)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            if (ram_we)
            begin
                wp_reg <= (wp_reg == ADDR_LAST) ? '0 : wp_reg + ADDR_W'(1);
                if (wp_reg == ADDR_LAST)
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            sample_reg <= write_sample;
            dly_reg    <= delay_amount;
        end
        if (state_reg == S_POS)
        begin
            i0_reg   <= rp_wrap[RP_W-1:FRAC_W];
            frac_reg <= rp_wrap[FRAC_W-1:0];
        end
        if (state_reg == S_PREP)
        begin
            addr_reg <= (i0_reg == '0) ? ADDR_LAST : i0_reg - ADDR_W'(1);
        end
        else if (state_reg == S_READ)
        begin
            addr_reg <= addr_inc;
        end
        if (ram_re)
        begin
            rd_ok_reg   <= wrapped_reg || (addr_reg < wp_reg);
            rd_slot_reg <= cnt_reg;
        end
        if (rd_pend_reg)
        begin
            tap_reg[rd_slot_reg] <= rd_ok_reg ? ram_rdata : '0;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_data_reg <= ist.result;
        end
    end

    cfdl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    cfdl_interp u_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ireq),
        .taps  (tap_reg),
        .stat  (ist)
    );

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("ring buffer written while a tap read is issued");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ist.done |-> state_reg == S_WAIT)
        else $error("interpolator finished outside the wait state");

    a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |=> wrapped_reg)
        else $error("buffer fill mark cleared without reset");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && out_free |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result not presented after leaving the output state");

endmodule

`default_nettype wire

@@ src/cfdl_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Self-contained; used for the sample ring buffer.
`default_nettype none

module cfdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/cfdl_interp.sv @@
// Catmull-Rom coefficient and Horner evaluation unit with one shared multiplier.
// Depends on cfdl_pkg for the sample, tap and handshake types.
`default_nettype none

module cfdl_interp
    import cfdl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfdl_req_t  req,
    input  wire tap_vec_t   taps,
    output cfdl_stat_t      stat
);

    typedef enum logic [4:0] {
        I_IDLE = 5'b00001,
        I_COEF = 5'b00010,
        I_MUL  = 5'b00100,
        I_ACC  = 5'b01000,
        I_FIN  = 5'b10000
    } istate_t;

    istate_t state_reg, state_next;
    logic [1:0] step_reg;
    logic       done_reg;
    sample_t    result_reg;
    acc_t       a_reg;
    acc_t       kc_reg [3];
    logic signed [PROD_W-1:0] prod_reg;

    acc_t em, e0, e1, e2;
    acc_t k0, k1, k2, k3;
    logic signed [FRAC_W:0]   frac_s;
    logic signed [PROD_W-1:0] prod_sum;
    logic signed [PROD_W-1:0] prod_rnd;
    acc_t a_next;
    acc_t half;
    acc_t sat;

    assign em = ACC_W'(taps[0]);
    assign e0 = ACC_W'(taps[1]);
    assign e1 = ACC_W'(taps[2]);
    assign e2 = ACC_W'(taps[3]);

    assign k0 = e0 <<< 1;
    assign k1 = e1 - em;
    assign k2 = (em <<< 1) - (e0 <<< 2) - e0 + (e1 <<< 2) - e2;
    assign k3 = (e2 - em) + ((e0 - e1) <<< 1) + (e0 - e1);

    assign frac_s   = {1'b0, req.frac};
    assign prod_sum = prod_reg + PROD_HALF;
    assign prod_rnd = prod_sum >>> FRAC_W;
    assign a_next   = prod_rnd[ACC_W-1:0] + kc_reg[step_reg];

    assign half = (a_reg + ACC_ONE) >>> 1;

    always_comb
    begin
        if (half > SAT_MAX)
        begin
            sat = SAT_MAX;
        end
        else if (half < SAT_MIN)
        begin
            sat = SAT_MIN;
        end
        else
        begin
            sat = half;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            I_IDLE:
            begin
                if (req.start)
                begin
                    state_next = I_COEF;
                end
            end
            I_COEF: state_next = I_MUL;
            I_MUL:  state_next = I_ACC;
            I_ACC:  state_next = (step_reg == 2'd2) ? I_FIN : I_MUL;
            I_FIN:  state_next = I_IDLE;
            default: state_next = I_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= I_IDLE;
            step_reg  <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == I_FIN);
            if (state_reg == I_COEF)
            begin
                step_reg <= 2'd0;
            end
            else if (state_reg == I_ACC)
            begin
                step_reg <= step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == I_COEF)
        begin
            a_reg     <= k3;
            kc_reg[0] <= k2;
            kc_reg[1] <= k1;
            kc_reg[2] <= k0;
        end
        if (state_reg == I_MUL)
        begin
            prod_reg <= a_reg * frac_s;
        end
        if (state_reg == I_ACC)
        begin
            a_reg <= a_next;
        end
        if (state_reg == I_FIN)
        begin
            result_reg <= sat[SAMPLE_W-1:0];
        end
    end

    assign stat.done   = done_reg;
    assign stat.result = result_reg;

endmodule

`default_nettype wire
